FILE: rtl/vscp_pkg.sv
// Shared types and constants for the voice steal channel picker.
// Used by vscp_ctrl, vscp_datapath and voice_steal_channel_picker; depends on nothing.
package vscp_pkg;

  localparam int ENTITY_W = 16;
  localparam int SLOT_W   = 4;
  localparam int TIME_W   = 31;
  localparam int INDEX_W  = 4;
  localparam int LIFE_W   = TIME_W + 1;

  localparam logic [0:0]        CMD_PICK  = 1'b0;
  localparam logic [0:0]        CMD_WRITE = 1'b1;
  localparam logic [SLOT_W-1:0] SLOT_NONE = 4'h0;
  localparam logic [SLOT_W-1:0] SLOT_ANY  = 4'hf;

  localparam logic signed [LIFE_W-1:0] LIFE_START = 32'sh7fff_ffff;

  typedef struct packed {
    logic [ENTITY_W-1:0] entity;
    logic [SLOT_W-1:0]   slot;
    logic [TIME_W-1:0]   end_time;
  } voice_t;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_WALK   = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  typedef struct packed {
    logic start;
    logic wr;
    logic walk;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic walk_done;
    logic out_free;
  } dp_status_t;

endpackage

FILE: rtl/vscp_ctrl.sv
// Controller state machine of the voice steal channel picker.
// Depends on vscp_pkg; drives commands into vscp_datapath and reads its status.
module vscp_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_cmd,
  output logic                   in_stall,
  input  vscp_pkg::dp_status_t   st,
  output vscp_pkg::ctrl_cmd_t    cmd
);

  vscp_pkg::state_t state_r, state_nxt;
  logic             accept;

  assign in_stall = (state_r != vscp_pkg::S_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    unique case (state_r)
      vscp_pkg::S_IDLE: begin
        if (accept) begin
          if (in_cmd == vscp_pkg::CMD_WRITE) begin
            cmd.wr = 1'b1;
          end else begin
            cmd.start = 1'b1;
            state_nxt = vscp_pkg::S_WALK;
          end
        end
      end
      vscp_pkg::S_WALK: begin
        cmd.walk = 1'b1;
        if (st.walk_done) begin
          state_nxt = vscp_pkg::S_FINISH;
        end
      end
      vscp_pkg::S_FINISH: begin
        if (st.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = vscp_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = vscp_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vscp_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/vscp_datapath.sv
// Datapath of the voice steal channel picker: voice memory, active and valid bits,
// walk pointer, shortest-life tracker, listener register and result register.
// Depends on vscp_pkg; sequenced by vscp_ctrl.
module vscp_datapath #(
  parameter int AMBIENT_VOICES = 4,
  parameter int DYNAMIC_VOICES = 8
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  vscp_pkg::ctrl_cmd_t                    cmd,
  output vscp_pkg::dp_status_t                   st,
  input  logic                                   cfg_we,
  input  logic [vscp_pkg::ENTITY_W-1:0]          cfg_data,
  input  logic [vscp_pkg::ENTITY_W-1:0]          in_req_entity,
  input  logic signed [vscp_pkg::SLOT_W-1:0]     in_req_slot,
  input  logic [vscp_pkg::TIME_W-1:0]            in_now_time,
  input  logic [vscp_pkg::INDEX_W-1:0]           in_entry_index,
  input  logic [vscp_pkg::ENTITY_W-1:0]          in_entry_entity,
  input  logic signed [vscp_pkg::SLOT_W-1:0]     in_entry_slot,
  input  logic [vscp_pkg::TIME_W-1:0]            in_entry_end,
  input  logic                                   in_entry_active,
  input  logic                                   out_stall,
  output logic                                   out_valid,
  output logic                                   out_found,
  output logic [vscp_pkg::INDEX_W-1:0]           out_picked_index
);

  localparam int TOTAL = AMBIENT_VOICES + DYNAMIC_VOICES;
  localparam int IDX_W = (TOTAL > 1) ? $clog2(TOTAL) : 1;
  localparam int PTR_W = $clog2(TOTAL + 1);
  localparam int CMP_W = (PTR_W > vscp_pkg::INDEX_W) ? PTR_W : vscp_pkg::INDEX_W;

  vscp_pkg::voice_t mem [TOTAL];
  logic [TOTAL-1:0] vld_r;
  logic [TOTAL-1:0] act_r;

  logic [vscp_pkg::ENTITY_W-1:0] view_r;
  logic [vscp_pkg::ENTITY_W-1:0] req_entity_r;
  logic [vscp_pkg::SLOT_W-1:0]   req_slot_r;
  logic [vscp_pkg::TIME_W-1:0]   now_r;

  logic [PTR_W-1:0]              ptr_r;
  logic                          rd_pend_r;
  logic [IDX_W-1:0]              rd_idx_r;
  vscp_pkg::voice_t              rd_data_r;
  logic                          rd_vld_r;
  logic                          hit_r;
  logic                          best_found_r;
  logic [IDX_W-1:0]              best_idx_r;
  logic signed [vscp_pkg::LIFE_W-1:0] life_r;

  logic                          out_valid_r;
  logic                          out_found_r;
  logic [vscp_pkg::INDEX_W-1:0]  out_idx_r;

  logic [CMP_W-1:0]              wr_idx_ext;
  logic                          wr_ok;
  logic                          issue;
  logic                          eval;
  vscp_pkg::voice_t              cur;
  logic                          cur_act;
  logic                          is_match;
  logic                          is_guarded;
  logic signed [vscp_pkg::LIFE_W-1:0] left;

  assign wr_idx_ext = CMP_W'(in_entry_index);
  assign wr_ok      = cmd.wr && (wr_idx_ext < CMP_W'(TOTAL));
  assign issue      = cmd.walk && !hit_r && (ptr_r != PTR_W'(TOTAL));
  assign eval       = cmd.walk && rd_pend_r && !hit_r;

  // A voice never written reads back as the all-zero reset entry.
  assign cur     = rd_vld_r ? rd_data_r : '0;
  assign cur_act = act_r[rd_idx_r];

  assign is_match = (req_slot_r != vscp_pkg::SLOT_NONE) && (cur.entity == req_entity_r) &&
                    ((cur.slot == req_slot_r) || (req_slot_r == vscp_pkg::SLOT_ANY));
  assign is_guarded = (cur.entity == view_r) && (req_entity_r != view_r) && cur_act;
  assign left = $signed({1'b0, cur.end_time}) - $signed({1'b0, now_r});

  assign st.walk_done = hit_r || (!rd_pend_r && (ptr_r == PTR_W'(TOTAL)));
  assign st.out_free  = !out_valid_r || !out_stall;

  // Voice memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[wr_idx_ext[IDX_W-1:0]] <= '{entity: in_entry_entity,
                                      slot: in_entry_slot,
                                      end_time: in_entry_end};
    end
    if (issue) begin
      rd_data_r <= mem[ptr_r[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      act_r <= '0;
    end else begin
      if (wr_ok) begin
        vld_r[wr_idx_ext[IDX_W-1:0]] <= 1'b1;
        act_r[wr_idx_ext[IDX_W-1:0]] <= in_entry_active;
      end
      if (cmd.finish && best_found_r) begin
        act_r[best_idx_r] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      view_r <= '0;
    end else if (cfg_we) begin
      view_r <= cfg_data;
    end
  end

  // Request capture and the walk over the dynamic voices.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r    <= 1'b0;
      hit_r        <= 1'b0;
      best_found_r <= 1'b0;
    end else if (cmd.start) begin
      rd_pend_r    <= 1'b0;
      hit_r        <= 1'b0;
      best_found_r <= 1'b0;
    end else begin
      rd_pend_r <= issue;
      if (eval) begin
        if (is_match) begin
          hit_r        <= 1'b1;
          best_found_r <= 1'b1;
        end else if (!is_guarded && (left < life_r)) begin
          best_found_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_entity_r <= in_req_entity;
      req_slot_r   <= in_req_slot;
      now_r        <= in_now_time;
      ptr_r        <= PTR_W'(AMBIENT_VOICES);
      best_idx_r   <= '0;
      life_r       <= vscp_pkg::LIFE_START;
    end else begin
      if (issue) begin
        rd_idx_r <= ptr_r[IDX_W-1:0];
        rd_vld_r <= vld_r[ptr_r[IDX_W-1:0]];
        ptr_r    <= ptr_r + PTR_W'(1);
      end
      if (eval) begin
        if (is_match) begin
          best_idx_r <= rd_idx_r;
        end else if (!is_guarded && (left < life_r)) begin
          best_idx_r <= rd_idx_r;
          life_r     <= left;
        end
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_found_r <= best_found_r;
      out_idx_r   <= best_found_r ? vscp_pkg::INDEX_W'(best_idx_r) : '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_found        = out_found_r;
  assign out_picked_index = out_idx_r;

endmodule

FILE: rtl/voice_steal_channel_picker.sv
// Top level of the voice steal channel picker.
// Depends on vscp_pkg, vscp_ctrl and vscp_datapath.
//
// The picker holds AMBIENT_VOICES + DYNAMIC_VOICES voice entries and answers a
// pick beat with the voice that a new sound should take, or with found low
// when every dynamic voice is protected or too long-lived. A write beat fills
// one entry (index beyond the table is dropped), gives no result and leaves
// the input ready. A pick beat walks the dynamic voices through the voice
// memory's one registered read port, one voice per cycle, with each compare
// in the cycle after its read; a walk that meets a matching entity and slot
// stops early. The result sits in an output register, so a write beat may be
// taken while a result waits. After reset all voices read as idle and zero at
// once: per-entry valid bits clear at reset, and there is no clearing pass.
// The listener entity is written through the configuration port, which is
// always ready and should be used only while the block is idle.
module voice_steal_channel_picker #(
  parameter int AMBIENT_VOICES = 4,
  parameter int DYNAMIC_VOICES = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [vscp_pkg::ENTITY_W-1:0]      cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_cmd,
  input  logic [vscp_pkg::ENTITY_W-1:0]      in_req_entity,
  input  logic signed [vscp_pkg::SLOT_W-1:0] in_req_slot,
  input  logic [vscp_pkg::TIME_W-1:0]        in_now_time,
  input  logic [vscp_pkg::INDEX_W-1:0]       in_entry_index,
  input  logic [vscp_pkg::ENTITY_W-1:0]      in_entry_entity,
  input  logic signed [vscp_pkg::SLOT_W-1:0] in_entry_slot,
  input  logic [vscp_pkg::TIME_W-1:0]        in_entry_end,
  input  logic                               in_entry_active,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_found,
  output logic [vscp_pkg::INDEX_W-1:0]       out_picked_index
);

  vscp_pkg::ctrl_cmd_t  cmd;
  vscp_pkg::dp_status_t st;

  // The listener register may be written in any cycle.
  assign cfg_ready = 1'b1;

  vscp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_cmd),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  vscp_datapath #(
    .AMBIENT_VOICES (AMBIENT_VOICES),
    .DYNAMIC_VOICES (DYNAMIC_VOICES)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .st               (st),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_data         (cfg_data),
    .in_req_entity    (in_req_entity),
    .in_req_slot      (in_req_slot),
    .in_now_time      (in_now_time),
    .in_entry_index   (in_entry_index),
    .in_entry_entity  (in_entry_entity),
    .in_entry_slot    (in_entry_slot),
    .in_entry_end     (in_entry_end),
    .in_entry_active  (in_entry_active),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_found        (out_found),
    .out_picked_index (out_picked_index)
  );

  // A pick beat starts a walk, so the input side must stall on the next cycle.
  a_pick_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_cmd == vscp_pkg::CMD_PICK)) |=> in_stall)
    else $error("input not stalled after a pick beat");

  // A write beat never starts a walk.
  a_write_no_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_cmd == vscp_pkg::CMD_WRITE)) |=> !in_stall)
    else $error("write beat left the picker busy");

  // A new result only appears after the controller finished a walk.
  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.finish))
    else $error("result appeared without a finished walk");

  // A walk is only finished when the result register can take it.
  a_finish_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_valid || !out_stall))
    else $error("result register overwritten while held");

endmodule
